// ----- hdl/xpw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xpw_pkg
// shared types and constants of the four-level page walker
// ----------------------------------------------------------------------------
package xpw_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_TABLE_ROOT  = 2'd0;
   localparam logic [1:0] CSR_PAGING_EN   = 2'd1;
   localparam logic [1:0] CSR_PAE_EN      = 2'd2;
   localparam logic [1:0] CSR_LONG_MODE   = 2'd3;

   // request operation codes
   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_READ_RSP  = 1'b1;

   // result kinds
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // walk status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NONCANON     = 3'd1;
   localparam logic [2:0] ST_MODE_OFF     = 3'd2;
   localparam logic [2:0] ST_NOT_PRESENT  = 3'd3;
   localparam logic [2:0] ST_READ_ERROR   = 3'd7;

   // page sizes
   localparam logic [1:0] SIZE_4K = 2'd0;
   localparam logic [1:0] SIZE_2M = 2'd1;
   localparam logic [1:0] SIZE_1G = 2'd2;

   // walk levels
   localparam logic [1:0] LVL_ROOT = 2'd0;
   localparam logic [1:0] LVL_PDPT = 2'd1;
   localparam logic [1:0] LVL_PD   = 2'd2;
   localparam logic [1:0] LVL_PT   = 2'd3;

   // entry bit positions
   localparam int BIT_PRESENT = 0;
   localparam int BIT_WRITE   = 1;
   localparam int BIT_USER    = 2;
   localparam int BIT_LARGE   = 7;
   localparam int BIT_NX      = 63;

   typedef struct packed {
      logic        operation;
      logic [63:0] virtual_address;
      logic [63:0] read_data;
      logic        read_ok;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [51:0] read_address;
      logic [2:0]  status;
      logic [51:0] physical_address;
      logic [1:0]  page_size;
      logic [2:0]  levels_read;
      logic        allowed_write;
      logic        allowed_user;
      logic        no_execute;
      logic [63:0] final_entry;
   } rsp_type;

   // classified beat handed from front to back
   typedef struct packed {
      logic        is_translate;
      logic        canonical;
      logic        mode_ok;
      logic [51:0] root_entry_addr;
      logic [63:0] virtual_address;
      logic [63:0] read_data;
      logic        read_ok;
   } cls_type;

endpackage
`default_nettype wire

// ----- hdl/xpw_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xpw_queue
// small first-in first-out queue of register entries
// ----------------------------------------------------------------------------
module xpw_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type wr_data,
   output logic          full,
   input  wire logic     pop,
   output item_type      rd_data,
   output logic          empty
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   item_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/xpw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xpw_front
// classifies incoming beats: canonical check, mode check, root entry address
// ----------------------------------------------------------------------------
module xpw_front #(
   parameter int PHYS_ADDR_BITS = 52
) (
   input  wire xpw_pkg::req_type req,
   input  wire logic [51:0]      table_root,
   input  wire logic             paging_enabled,
   input  wire logic             pae_enabled,
   input  wire logic             long_mode_active,
   output xpw_pkg::cls_type      cls
);
   import xpw_pkg::*;

   localparam logic [51:0] PHYS_MASK = {52{1'b1}} >> (52 - PHYS_ADDR_BITS);

   logic [63:0] va;

   assign va = req.virtual_address;

   always_comb begin
      cls                 = '0;
      cls.is_translate    = (req.operation == OP_TRANSLATE);
      cls.canonical       = (va[63:48] == {16{va[47]}});
      cls.mode_ok         = paging_enabled && pae_enabled && long_mode_active;
      cls.root_entry_addr = {table_root[51:12], va[47:39], 3'b000} & PHYS_MASK;
      cls.virtual_address = va;
      cls.read_data       = req.read_data;
      cls.read_ok         = req.read_ok;
   end

endmodule
`default_nettype wire

// ----- hdl/xpw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xpw_back
// walk engine: holds walk state; each beat but a stray read response gives a result
// ----------------------------------------------------------------------------
module xpw_back #(
   parameter int PHYS_ADDR_BITS = 52
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire xpw_pkg::cls_type cls,
   input  wire logic             cls_empty,
   output logic                  cls_pop,
   input  wire logic             rsp_full,
   output logic                  rsp_push,
   output xpw_pkg::rsp_type      rsp
);
   import xpw_pkg::*;

   localparam logic [51:0] PHYS_MASK = {52{1'b1}} >> (52 - PHYS_ADDR_BITS);

   logic        busy_ff, busy_in;
   logic [1:0]  level_ff, level_in;
   logic [63:0] vaddr_ff, vaddr_in;
   logic        acc_write_ff, acc_write_in;
   logic        acc_user_ff, acc_user_in;
   logic        acc_nx_ff, acc_nx_in;

   logic [63:0] entry;
   logic [1:0]  next_level;
   logic [8:0]  next_index;

   assign entry      = cls.read_data;
   assign next_level = level_ff + 2'd1;

   // table index of the next level from the held address
   always_comb begin
      case (next_level)
         LVL_ROOT: next_index = vaddr_ff[47:39];
         LVL_PDPT: next_index = vaddr_ff[38:30];
         LVL_PD:   next_index = vaddr_ff[29:21];
         LVL_PT:   next_index = vaddr_ff[20:12];
         default:  next_index = vaddr_ff[20:12];
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      level_in     = level_ff;
      vaddr_in     = vaddr_ff;
      acc_write_in = acc_write_ff;
      acc_user_in  = acc_user_ff;
      acc_nx_in    = acc_nx_ff;
      rsp          = '0;
      rsp_push     = 1'b0;
      cls_pop      = !cls_empty && !rsp_full;

      if (cls_pop) begin
         if (cls.is_translate) begin
            // a new request drops any running walk
            busy_in      = 1'b0;
            level_in     = LVL_ROOT;
            vaddr_in     = cls.virtual_address;
            acc_write_in = 1'b1;
            acc_user_in  = 1'b1;
            acc_nx_in    = 1'b0;
            rsp_push     = 1'b1;
            if (!cls.canonical || !cls.mode_ok) begin
               rsp.kind          = KIND_DONE;
               rsp.status        = cls.canonical ? ST_MODE_OFF : ST_NONCANON;
               rsp.allowed_write = 1'b1;
               rsp.allowed_user  = 1'b1;
            end else begin
               rsp.kind         = KIND_READ;
               rsp.read_address = cls.root_entry_addr;
               busy_in          = 1'b1;
            end
         end else if (busy_ff) begin
            rsp_push = 1'b1;
            if (!cls.read_ok) begin
               rsp.kind          = KIND_DONE;
               rsp.status        = ST_READ_ERROR;
               rsp.levels_read   = {1'b0, level_ff};
               rsp.allowed_write = acc_write_ff;
               rsp.allowed_user  = acc_user_ff;
               rsp.no_execute    = acc_nx_ff;
               busy_in           = 1'b0;
            end else begin
               acc_write_in = acc_write_ff & entry[BIT_WRITE];
               acc_user_in  = acc_user_ff & entry[BIT_USER];
               acc_nx_in    = acc_nx_ff | entry[BIT_NX];
               // finished fields, overridden for a further read below
               rsp.kind          = KIND_DONE;
               rsp.levels_read   = {1'b0, level_ff} + 3'd1;
               rsp.allowed_write = acc_write_in;
               rsp.allowed_user  = acc_user_in;
               rsp.no_execute    = acc_nx_in;
               rsp.final_entry   = entry;
               busy_in           = 1'b0;
               if (!entry[BIT_PRESENT]) begin
                  rsp.status = ST_NOT_PRESENT + {1'b0, level_ff};
               end else if (level_ff == LVL_PDPT && entry[BIT_LARGE]) begin
                  rsp.status           = ST_OK;
                  rsp.page_size        = SIZE_1G;
                  rsp.physical_address = {entry[51:30], vaddr_ff[29:0]} & PHYS_MASK;
               end else if (level_ff == LVL_PD && entry[BIT_LARGE]) begin
                  rsp.status           = ST_OK;
                  rsp.page_size        = SIZE_2M;
                  rsp.physical_address = {entry[51:21], vaddr_ff[20:0]} & PHYS_MASK;
               end else if (level_ff == LVL_PT) begin
                  rsp.status           = ST_OK;
                  rsp.page_size        = SIZE_4K;
                  rsp.physical_address = {entry[51:12], vaddr_ff[11:0]} & PHYS_MASK;
               end else begin
                  rsp              = '0;
                  rsp.kind         = KIND_READ;
                  rsp.read_address = {entry[51:12], next_index, 3'b000} & PHYS_MASK;
                  level_in         = next_level;
                  busy_in          = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         level_ff     <= LVL_ROOT;
         acc_write_ff <= 1'b1;
         acc_user_ff  <= 1'b1;
         acc_nx_ff    <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         level_ff     <= level_in;
         acc_write_ff <= acc_write_in;
         acc_user_ff  <= acc_user_in;
         acc_nx_ff    <= acc_nx_in;
      end
   end

   always_ff @(posedge clock) begin
      vaddr_ff <= vaddr_in;
   end

endmodule
`default_nettype wire

// ----- hdl/x64_four_level_page_walker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x64_four_level_page_walker
// four-level long-mode page table walker with queue interfaces
// ----------------------------------------------------------------------------
// Translates 64-bit virtual addresses by walking long-mode page tables held in
// an external memory. A translate beat is checked for a canonical address and
// for paging, PAE and long mode being on; it then yields a read request for the
// root entry. The caller performs each read and pushes the entry back as a read
// response beat, which yields either the next read request or the finished
// translation. One beat is taken every cycle: the back end finishes each beat
// in a single step, so the sustained rate is one beat per cycle while the
// result side keeps popping. An accepted beat waits in the front-to-back queue;
// its result is registered in the result queue, whose head drives the rsp_
// ports. Configuration writes are always accepted (csr_ready is tied high) and
// must only be made while no walk is in progress.
// ----------------------------------------------------------------------------
module x64_four_level_page_walker #(
   parameter int PHYS_ADDR_BITS = 52
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // translate requests and read responses
   input  wire logic             req_push,
   input  wire xpw_pkg::req_type req_data,
   output logic                  req_full,
   // read requests and finished translations
   output logic                  rsp_empty,
   output xpw_pkg::rsp_type      rsp_data,
   input  wire logic             rsp_pop,
   // configuration
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [51:0]      csr_data
);
   import xpw_pkg::*;

   // configuration registers
   logic [51:0] table_root_ff;
   logic        paging_en_ff;
   logic        pae_en_ff;
   logic        long_mode_ff;

   // front to back queue
   cls_type cls_wr;
   cls_type cls_rd;
   logic    cls_empty;
   logic    cls_pop;

   // back to result queue
   rsp_type rsp_wr;
   logic    rsp_push;
   logic    rsp_full;

   assign csr_ready = 1'b1;

   // register writes, one-bit registers keep only bit 0
   always_ff @(posedge clock) begin
      if (reset) begin
         table_root_ff <= '0;
         paging_en_ff  <= 1'b0;
         pae_en_ff     <= 1'b0;
         long_mode_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TABLE_ROOT: table_root_ff <= csr_data;
            CSR_PAGING_EN:  paging_en_ff  <= csr_data[0];
            CSR_PAE_EN:     pae_en_ff     <= csr_data[0];
            CSR_LONG_MODE:  long_mode_ff  <= csr_data[0];
            default:        table_root_ff <= table_root_ff;
         endcase
      end
   end

   // front end: classify each beat as it arrives
   xpw_front #(
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) u_front (
      .req              (req_data),
      .table_root       (table_root_ff),
      .paging_enabled   (paging_en_ff),
      .pae_enabled      (pae_en_ff),
      .long_mode_active (long_mode_ff),
      .cls              (cls_wr)
   );

   // decouples intake from the walk engine
   xpw_queue #(
      .item_type (cls_type),
      .DEPTH     (2)
   ) u_cls_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (cls_wr),
      .full    (req_full),
      .pop     (cls_pop),
      .rd_data (cls_rd),
      .empty   (cls_empty)
   );

   // back end: walk state, one beat per step
   xpw_back #(
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cls       (cls_rd),
      .cls_empty (cls_empty),
      .cls_pop   (cls_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   // result queue, lets the engine run while a result waits
   xpw_queue #(
      .item_type (rsp_type),
      .DEPTH     (2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

endmodule
`default_nettype wire

// ----- tb/x64_four_level_page_walker_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x64_four_level_page_walker_test
// self-checking bench for the four-level page walker
// ----------------------------------------------------------------------------
// The bench stands in for the memory behind the walker: it pushes translate
// beats and answers each walk with table entries of its own choosing. A copy
// of the walk kept in the bench works out the result of every accepted beat,
// and results are popped with random stalls and compared field by field in
// order. A short table of directed beats runs first, then phases of random
// walks, each under its own register setting.
// ----------------------------------------------------------------------------
module x64_four_level_page_walker_test;
   import xpw_pkg::*;

   localparam int IDLE_LIMIT    = 1000;  // cycles without any handshake
   localparam int RANDOM_BEATS  = 900;
   localparam int PHASES        = 9;
   localparam int SETTLE_CYCLES = 4;     // spare cycles once nothing is owed

   logic        clock;
   logic        reset;
   logic        req_push;
   req_type     req_data;
   logic        req_full;
   logic        rsp_empty;
   rsp_type     rsp_data;
   logic        rsp_pop;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [51:0] csr_data;

   x64_four_level_page_walker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // bench copy of the registers and of the walk in flight
   logic [51:0] root_reg;
   logic        paging_on;
   logic        pae_on;
   logic        long_mode_on;
   logic        walking;
   logic [1:0]  walk_lvl;
   logic [63:0] walk_va;
   logic        and_write;
   logic        and_user;
   logic        or_nx;

   rsp_type     walk_results[$];   // results still owed by the walker, oldest first
   int          mismatches = 0;
   bit          quiet = 1'b0;      // both sides run back to back while set
   int          idle_cycles = 0;

   // one row of the directed table: a register write or a request beat
   typedef struct {
      bit          is_csr;
      logic [1:0]  csr_idx;
      logic [51:0] csr_value;
      req_type     beat;
      bit          typed;     // golden result written out in the row
      rsp_type     golden;
   } plan_row_type;

   plan_row_type plan[$];

   // appends a result to the owed list
   function automatic void owe_result(input rsp_type r);
      walk_results.insert(walk_results.size(), r);
   endfunction

   // appends a row to the directed table
   function automatic void plan_add(input plan_row_type r);
      plan.insert(plan.size(), r);
   endfunction

   // ends the walk and builds the finished-translation beat
   function automatic rsp_type walk_done(input logic [2:0] status, input logic [51:0] pa,
                                         input logic [1:0] size, input logic [2:0] nread,
                                         input logic [63:0] entry);
      rsp_type r;
      r                  = '0;
      r.kind             = KIND_DONE;
      r.status           = status;
      r.physical_address = pa;
      r.page_size        = size;
      r.levels_read      = nread;
      r.allowed_write    = and_write;
      r.allowed_user     = and_user;
      r.no_execute       = or_nx;
      r.final_entry      = entry;
      walking            = 1'b0;
      return r;
   endfunction

   // advances the walk by one accepted beat; returns 0 when no result follows
   function automatic bit walk_predict(input req_type beat, output rsp_type res);
      logic [63:0] e;
      logic [1:0]  lvl;
      logic [8:0]  idx;
      res = '0;
      if (beat.operation == OP_TRANSLATE) begin
         // a new request always starts afresh, dropping any walk in flight
         walking   = 1'b0;
         walk_lvl  = LVL_ROOT;
         and_write = 1'b1;
         and_user  = 1'b1;
         or_nx     = 1'b0;
         walk_va   = beat.virtual_address;
         if (walk_va[63:48] != {16{walk_va[47]}})
            res = walk_done(ST_NONCANON, '0, SIZE_4K, 3'd0, '0);
         else if (!(paging_on && pae_on && long_mode_on))
            res = walk_done(ST_MODE_OFF, '0, SIZE_4K, 3'd0, '0);
         else begin
            walking          = 1'b1;
            res.kind         = KIND_READ;
            res.read_address = {root_reg[51:12], walk_va[47:39], 3'b000};
         end
         return 1'b1;
      end
      // stray entry with no walk running: dropped silently
      if (!walking)
         return 1'b0;
      lvl = walk_lvl;
      e   = beat.read_data;
      if (!beat.read_ok) begin
         res = walk_done(ST_READ_ERROR, '0, SIZE_4K, {1'b0, lvl}, '0);
         return 1'b1;
      end
      // permissions fold in every entry read, the failing one too
      and_write = and_write & e[BIT_WRITE];
      and_user  = and_user & e[BIT_USER];
      or_nx     = or_nx | e[BIT_NX];
      if (!e[BIT_PRESENT])
         res = walk_done(ST_NOT_PRESENT + lvl, '0, SIZE_4K, lvl + 3'd1, e);
      else if (lvl == LVL_PDPT && e[BIT_LARGE])
         res = walk_done(ST_OK, {e[51:30], walk_va[29:0]}, SIZE_1G, 3'd2, e);
      else if (lvl == LVL_PD && e[BIT_LARGE])
         res = walk_done(ST_OK, {e[51:21], walk_va[20:0]}, SIZE_2M, 3'd3, e);
      else if (lvl == LVL_PT)
         res = walk_done(ST_OK, {e[51:12], walk_va[11:0]}, SIZE_4K, 3'd4, e);
      else begin
         // large bit of a root entry means nothing, so the root always descends
         walk_lvl         = lvl + 2'd1;
         idx              = 9'(walk_va >> (39 - 9 * walk_lvl));
         res.kind         = KIND_READ;
         res.read_address = {e[51:12], idx, 3'b000};
      end
      return 1'b1;
   endfunction

   function automatic int unsigned draw_gap();
      if (quiet)
         return 0;
      return $urandom_range(0, 16);
   endfunction

   // random upper bits around the one bit that counts
   function automatic logic [51:0] flag_word(input bit on);
      logic [51:0] w;
      w    = 52'({$urandom, $urandom});
      w[0] = on;
      return w;
   endfunction

   function automatic rsp_type typed_rsp(input logic kind, input logic [51:0] addr,
                                         input logic [2:0] status, input logic [2:0] nread,
                                         input logic w, input logic u);
      rsp_type r;
      r               = '0;
      r.kind          = kind;
      r.read_address  = addr;
      r.status        = status;
      r.levels_read   = nread;
      r.allowed_write = w;
      r.allowed_user  = u;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [1:0] idx, input logic [51:0] value);
      plan_row_type r;
      r           = '{default: '0};
      r.is_csr    = 1'b1;
      r.csr_idx   = idx;
      r.csr_value = value;
      return r;
   endfunction

   // fields that the operation does not use are filled with noise
   function automatic plan_row_type beat_row(input logic op, input logic [63:0] word,
                                             input logic ok, input bit typed = 1'b0,
                                             input rsp_type golden = '0);
      plan_row_type r;
      r                      = '{default: '0};
      r.beat.operation       = op;
      r.beat.virtual_address = {$urandom, $urandom};
      r.beat.read_data       = {$urandom, $urandom};
      r.beat.read_ok         = ok;
      if (op == OP_TRANSLATE)
         r.beat.virtual_address = word;
      else
         r.beat.read_data = word;
      r.typed  = typed;
      r.golden = golden;
      return r;
   endfunction

   // one request beat: optional gap, then hold push until the walker takes it
   task automatic push_beat(input req_type beat, input bit typed, input rsp_type golden);
      int unsigned gap;
      rsp_type     res;
      bit          produces;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= beat;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      produces = walk_predict(beat, res);
      if (typed)
         owe_result(golden);
      else if (produces)
         owe_result(res);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [51:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TABLE_ROOT: root_reg     = value;
         CSR_PAGING_EN:  paging_on    = value[0];
         CSR_PAE_EN:     pae_on       = value[0];
         CSR_LONG_MODE:  long_mode_on = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop pushing, let every owed result drain, then a few spare cycles
   task automatic settle();
      int n;
      @(negedge clock);
      req_push <= 1'b0;
      for (n = 0; n < IDLE_LIMIT && walk_results.size() > 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (walk_results.size() > 0) begin
         $display("%0t: %0d results never arrived, oldest expected %p", $time,
                  walk_results.size(), walk_results[0]);
         mismatches++;
         walk_results.delete();
      end
   endtask

   task automatic random_phase(input int beats);
      int      n;
      bit      stray;
      req_type beat;
      n = 0;
      while (n < beats) begin
         // every so often flip between back-to-back traffic and gappy traffic
         if (n % 40 == 0)
            quiet = ($urandom_range(0, 3) == 0);
         beat.virtual_address = {$urandom, $urandom};
         beat.read_data       = {$urandom, $urandom};
         beat.read_ok         = ($urandom_range(0, 29) != 0);
         stray                = !walking && ($urandom_range(0, 19) == 0);
         if (stray)
            beat.operation = OP_READ_RSP;
         else if (!walking || $urandom_range(0, 24) == 0) begin
            // mostly canonical, now and then a broken upper half
            beat.operation = OP_TRANSLATE;
            if ($urandom_range(0, 9) != 0)
               beat.virtual_address[63:48] = {16{beat.virtual_address[47]}};
         end else begin
            // mostly present entries, so walks reach the lower levels
            beat.operation                = OP_READ_RSP;
            beat.read_data[BIT_PRESENT]   = ($urandom_range(0, 11) != 0);
            beat.read_data[BIT_LARGE]     = ($urandom_range(0, 2) == 0);
         end
         push_beat(beat, 1'b0, '0);
         if (!stray)
            n++;
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result side: pop with random stalls, check each beat against the oldest owed
   initial begin : result_side
      int unsigned gap;
      rsp_type     want;
      rsp_pop = 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = draw_gap();
         @(negedge clock);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         if (walk_results.size() == 0) begin
            $display("%0t: result beat with nothing owed, expected none, got %p",
                     $time, rsp_data);
            mismatches++;
         end else begin
            want = walk_results.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_data.kind));
            check_field("read_address", 64'(want.read_address), 64'(rsp_data.read_address));
            check_field("status", 64'(want.status), 64'(rsp_data.status));
            check_field("physical_address", 64'(want.physical_address),
                        64'(rsp_data.physical_address));
            check_field("page_size", 64'(want.page_size), 64'(rsp_data.page_size));
            check_field("levels_read", 64'(want.levels_read), 64'(rsp_data.levels_read));
            check_field("allowed_write", 64'(want.allowed_write), 64'(rsp_data.allowed_write));
            check_field("allowed_user", 64'(want.allowed_user), 64'(rsp_data.allowed_user));
            check_field("no_execute", 64'(want.no_execute), 64'(rsp_data.no_execute));
            check_field("final_entry", want.final_entry, rsp_data.final_entry);
         end
      end
   end

   // watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if (reset)
         idle_cycles <= 0;
      else if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int          phase;
      bit          all_on;
      logic [51:0] root;
      req_type     closer;

      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_TABLE_ROOT;
      csr_data  = '0;

      // bench state as after reset
      root_reg     = '0;
      paging_on    = 1'b0;
      pae_on       = 1'b0;
      long_mode_on = 1'b0;
      walking      = 1'b0;
      walk_lvl     = LVL_ROOT;
      walk_va      = '0;
      and_write    = 1'b1;
      and_user     = 1'b1;
      or_nx        = 1'b0;

      // directed table; golden results only where they are plain to see
      // registers still at reset: a canonical address fails the mode check
      plan_add(beat_row(OP_TRANSLATE, 64'h0000_0000_0000_0000, 1'b1, 1'b1,
                        typed_rsp(KIND_DONE, '0, ST_MODE_OFF, 3'd0, 1'b1, 1'b1)));
      // upper half zero but bit 47 set, then the mirror case
      plan_add(beat_row(OP_TRANSLATE, 64'h0000_8000_0000_0000, 1'b1, 1'b1,
                        typed_rsp(KIND_DONE, '0, ST_NONCANON, 3'd0, 1'b1, 1'b1)));
      plan_add(beat_row(OP_TRANSLATE, 64'hFFFF_7FFF_FFFF_FFFF, 1'b0, 1'b1,
                        typed_rsp(KIND_DONE, '0, ST_NONCANON, 3'd0, 1'b1, 1'b1)));
      // entry arriving with no walk running
      plan_add(beat_row(OP_READ_RSP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
      plan_add(csr_row(CSR_TABLE_ROOT, 52'hF_FFFF_FFFF_FFFF));
      plan_add(csr_row(CSR_PAGING_EN, 52'h0_0000_0000_0001));
      plan_add(csr_row(CSR_PAE_EN, 52'hF_FFFF_FFFF_FFFF));
      // long mode still off
      plan_add(beat_row(OP_TRANSLATE, 64'hFFFF_8000_0000_0000, 1'b1, 1'b1,
                        typed_rsp(KIND_DONE, '0, ST_MODE_OFF, 3'd0, 1'b1, 1'b1)));
      plan_add(csr_row(CSR_LONG_MODE, 52'h0_0000_0000_0001));
      // top of the root table, low root bits ignored
      plan_add(beat_row(OP_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
                        typed_rsp(KIND_READ, 52'hF_FFFF_FFFF_FFF8, ST_OK, 3'd0,
                                  1'b0, 1'b0)));
      // failed read of the root entry
      plan_add(beat_row(OP_READ_RSP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
                        typed_rsp(KIND_DONE, '0, ST_READ_ERROR, 3'd0, 1'b1, 1'b1)));
      plan_add(beat_row(OP_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
                        typed_rsp(KIND_READ, 52'hF_FFFF_FFFF_FFF8, ST_OK, 3'd0,
                                  1'b0, 1'b0)));
      // all-zero root entry: not present at the first level
      plan_add(beat_row(OP_READ_RSP, 64'h0000_0000_0000_0000, 1'b1, 1'b1,
                        typed_rsp(KIND_DONE, '0, ST_NOT_PRESENT, 3'd1, 1'b0, 1'b0)));
      plan_add(csr_row(CSR_TABLE_ROOT, 52'h0_0000_0000_0000));
      // 1 GiB page; large bit on the root entry has no effect
      plan_add(beat_row(OP_TRANSLATE, 64'h0000_7FFF_FFFF_FFFF, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h0000_0000_4000_0087, 1'b1));
      // walk dropped by a fresh translate, then a 2 MiB page with NX
      plan_add(beat_row(OP_TRANSLATE, 64'hFFFF_8000_0020_1ABC, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h0000_0000_0000_1007, 1'b1));
      plan_add(beat_row(OP_TRANSLATE, 64'hFFFF_8000_0020_1ABC, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h0000_0000_0000_1007, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h0000_0000_0000_2007, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h8000_0000_0060_0083, 1'b1));
      // full 4 KiB walk, entry address bits at the top of the range
      plan_add(beat_row(OP_TRANSLATE, 64'h0000_1234_5678_9ABC, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h7FFF_FFFF_FFFF_F007, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h0000_0000_0000_3003, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h0000_0000_0000_4005, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h000F_FFFF_FFFF_F8E7, 1'b1));
      // last-level entry not present
      plan_add(beat_row(OP_TRANSLATE, 64'h0000_0000_0000_0000, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h0000_0000_0000_1007, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h0000_0000_0000_1003, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h0000_0000_0000_1001, 1'b1));
      plan_add(beat_row(OP_READ_RSP, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            write_csr(plan[i].csr_idx, plan[i].csr_value);
         end else
            push_beat(plan[i].beat, plan[i].typed, plan[i].golden);
      end

      // random phases; registers change only once the walker has gone quiet
      closer                 = '0;
      closer.operation       = OP_TRANSLATE;
      closer.virtual_address = 64'h0000_8000_0000_0000;
      for (phase = 0; phase < PHASES; phase++) begin
         if (walking)
            push_beat(closer, 1'b0, '0);
         settle();
         case (phase)
            0:       root = '0;
            1:       root = '1;
            default: root = 52'({$urandom, $urandom});
         endcase
         // every fourth phase has the mode bits drawn at random
         all_on = (phase % 4 != 3);
         write_csr(CSR_TABLE_ROOT, root);
         write_csr(CSR_PAGING_EN, flag_word(all_on || $urandom_range(0, 1)));
         write_csr(CSR_PAE_EN, flag_word(all_on || $urandom_range(0, 1)));
         write_csr(CSR_LONG_MODE, flag_word(all_on || $urandom_range(0, 1)));
         random_phase(RANDOM_BEATS / PHASES);
      end

      settle();
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/xpw_pkg.sv
hdl/xpw_queue.sv
hdl/xpw_front.sv
hdl/xpw_back.sv
hdl/x64_four_level_page_walker.sv
tb/x64_four_level_page_walker_test.sv
